>>> hw/rtl/rrr_pkg.sv
package rrr_pkg;

  // Fixed point format of the ports: signed Q4.28 in a 32-bit word.
  localparam int WordBits  = 32;
  localparam int FracBits  = 28;
  localparam int EtaBits   = WordBits - 1;

  // Intermediate sums and products after rescaling stay well inside this width.
  localparam int AccBits   = 48;

  // Wide products are split into a high part and a low part of this many bits.
  localparam int SplitBits = 16;
  localparam int HiBits    = AccBits - SplitBits;
  localparam int LoProdBits = WordBits + SplitBits + 1;
  localparam int HiProdBits = WordBits + HiBits;
  localparam int JoinBits   = HiProdBits + SplitBits;

  // Square root: the root has FracBits + 1 bits, the remainder twice that.
  localparam int RootBits          = FracBits + 1;
  localparam int RemBits           = 2 * FracBits + 2;
  localparam int SqrtStepsPerStage = 4;
  localparam int SqrtStages        = (RootBits + SqrtStepsPerStage - 1) / SqrtStepsPerStage;

  typedef logic signed [WordBits-1:0] word_t;
  typedef logic signed [AccBits-1:0]  acc_t;

  localparam acc_t One = acc_t'(1) <<< FracBits;

  typedef enum logic {
    OpReflect = 1'b0,
    OpRefract = 1'b1
  } op_e;

  typedef struct packed {
    op_e                 opcode;
    word_t               dir_x;
    word_t               dir_y;
    word_t               dir_z;
    word_t               norm_x;
    word_t               norm_y;
    word_t               norm_z;
    logic [EtaBits-1:0]  index_ratio;
  } in_t;

  typedef struct packed {
    word_t out_x;
    word_t out_y;
    word_t out_z;
    logic  total_internal;
  } out_t;

  // Handoff from the dot product section to the index ratio section.
  typedef struct packed {
    op_e                op;
    word_t [2:0]        norm;
    acc_t  [2:0]        mix;
    logic [EtaBits-1:0] eta;
  } mix_t;

  // Handoff into and through the square root pipeline.
  typedef struct packed {
    op_e                 op;
    logic                tir;
    word_t [2:0]         norm;
    acc_t  [2:0]         val;
    logic [RemBits-1:0]  rem;
    logic [RootBits-1:0] root;
  } sq_t;

  // Floor of a product divided by the fraction scale.
  function automatic acc_t fx_shift(input logic signed [JoinBits-1:0] x);
    logic signed [JoinBits-1:0] s;
    s = x >>> FracBits;
    return s[AccBits-1:0];
  endfunction

  // Recombine the two partial products of a split multiplication.
  function automatic logic signed [JoinBits-1:0] pp_join(
    input logic signed [HiProdBits-1:0] hi,
    input logic signed [LoProdBits-1:0] lo
  );
    logic signed [JoinBits-1:0] j;
    j = $signed({hi, {SplitBits{1'b0}}});
    j = j + lo;
    return j;
  endfunction

endpackage

>>> hw/rtl/ray_reflect_refract_top.sv
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+---------------------------
// in       | input     | in_valid_i / in_stall_o    | in_data_i  (rrr_pkg::in_t)
// out      | output    | out_valid_o / out_stall_i  | out_data_o (rrr_pkg::out_t)
//
// One transaction is accepted per cycle while the output is not stalled; each gives one
// result after 4 dot product stages, 4 index ratio stages, 8 square root stages and 2 output.
// The square root pipeline, four root bits per stage, is the deepest section.
// Reset clears only the valid bits; no clearing pass is needed.
// A stall on the output freezes the whole pipeline and stalls the input.
module ray_reflect_refract_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rrr_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rrr_pkg::out_t out_data_o
);

  logic          en;
  logic          mix_valid, eta_valid, root_valid;
  rrr_pkg::mix_t mix;
  rrr_pkg::sq_t  eta_sq, root_sq;

  // The pipeline moves unless a finished result is held by the consumer.
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  rrr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .item_i  (in_data_i),
    .valid_o (mix_valid),
    .mix_o   (mix)
  );

  rrr_eta u_eta (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mix_valid),
    .mix_i   (mix),
    .valid_o (eta_valid),
    .sq_o    (eta_sq)
  );

  rrr_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (eta_valid),
    .sq_i    (eta_sq),
    .valid_o (root_valid),
    .sq_o    (root_sq)
  );

  rrr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (root_valid),
    .sq_i    (root_sq),
    .valid_o (out_valid_o),
    .out_o   (out_data_o)
  );

endmodule

>>> hw/rtl/rrr_front.sv
module rrr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  rrr_pkg::in_t  item_i,
  output logic          valid_o,
  output rrr_pkg::mix_t mix_o
);

  rrr_pkg::word_t [2:0] d_in, n_in;

  assign d_in = {item_i.dir_z, item_i.dir_y, item_i.dir_x};
  assign n_in = {item_i.norm_z, item_i.norm_y, item_i.norm_x};

  // Stage 1: per-component products of direction and normal.
  logic                                v1_q;
  rrr_pkg::op_e                        op1_q;
  rrr_pkg::word_t [2:0]                d1_q, n1_q;
  logic [rrr_pkg::EtaBits-1:0]         eta1_q;
  rrr_pkg::acc_t  [2:0]                dn1_d, dn1_q;

  always_comb begin
    logic signed [2*rrr_pkg::WordBits-1:0] prod;
    for (int i = 0; i < 3; i++) begin
      prod = $signed(d_in[i]) * $signed(n_in[i]);
      if (item_i.opcode == rrr_pkg::OpRefract) begin
        dn1_d[i] = rrr_pkg::fx_shift(-prod);
      end else begin
        dn1_d[i] = rrr_pkg::fx_shift(prod);
      end
    end
  end

  // Stage 2: dot product and the scale factor for the normal.
  logic                        v2_q;
  rrr_pkg::op_e                op2_q;
  rrr_pkg::word_t [2:0]        d2_q, n2_q;
  logic [rrr_pkg::EtaBits-1:0] eta2_q;
  rrr_pkg::acc_t               dot, coef2_d, coef2_q;

  always_comb begin
    dot = dn1_q[0] + dn1_q[1] + dn1_q[2];
    if (op1_q == rrr_pkg::OpRefract) begin
      coef2_d = (dot > rrr_pkg::One) ? rrr_pkg::One : dot;
    end else begin
      coef2_d = dot + dot;
    end
  end

  // Stage 3: normal times the scale factor, as two partial products.
  logic                        v3_q;
  rrr_pkg::op_e                op3_q;
  rrr_pkg::word_t [2:0]        d3_q, n3_q;
  logic [rrr_pkg::EtaBits-1:0] eta3_q;
  logic signed [rrr_pkg::HiProdBits-1:0] ph3_d [3];
  logic signed [rrr_pkg::HiProdBits-1:0] ph3_q [3];
  logic signed [rrr_pkg::LoProdBits-1:0] pl3_d [3];
  logic signed [rrr_pkg::LoProdBits-1:0] pl3_q [3];

  always_comb begin
    logic signed [rrr_pkg::HiBits-1:0]    hi;
    logic signed [rrr_pkg::SplitBits:0]   lo;
    hi = $signed(coef2_q[rrr_pkg::AccBits-1:rrr_pkg::SplitBits]);
    lo = $signed({1'b0, coef2_q[rrr_pkg::SplitBits-1:0]});
    for (int i = 0; i < 3; i++) begin
      ph3_d[i] = $signed(n2_q[i]) * hi;
      pl3_d[i] = $signed(n2_q[i]) * lo;
    end
  end

  // Stage 4: rescale and combine with the direction.
  logic                        v4_q;
  rrr_pkg::mix_t               mix4_d, mix4_q;

  always_comb begin
    rrr_pkg::acc_t nc;
    rrr_pkg::acc_t dx;
    mix4_d.op   = op3_q;
    mix4_d.norm = n3_q;
    mix4_d.eta  = eta3_q;
    for (int i = 0; i < 3; i++) begin
      nc = rrr_pkg::fx_shift(rrr_pkg::pp_join(ph3_q[i], pl3_q[i]));
      dx = rrr_pkg::acc_t'(d3_q[i]);
      if (op3_q == rrr_pkg::OpRefract) begin
        mix4_d.mix[i] = dx + nc;
      end else begin
        mix4_d.mix[i] = dx - nc;
      end
    end
  end

  // Valid bits advance with the shared pipeline enable.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op1_q   <= item_i.opcode;
      d1_q    <= d_in;
      n1_q    <= n_in;
      eta1_q  <= item_i.index_ratio;
      dn1_q   <= dn1_d;
      op2_q   <= op1_q;
      d2_q    <= d1_q;
      n2_q    <= n1_q;
      eta2_q  <= eta1_q;
      coef2_q <= coef2_d;
      op3_q   <= op2_q;
      d3_q    <= d2_q;
      n3_q    <= n2_q;
      eta3_q  <= eta2_q;
      ph3_q   <= ph3_d;
      pl3_q   <= pl3_d;
      mix4_q  <= mix4_d;
    end
  end

  assign valid_o = v4_q;
  assign mix_o   = mix4_q;

endmodule

>>> hw/rtl/rrr_eta.sv
module rrr_eta (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  rrr_pkg::mix_t mix_i,
  output logic          valid_o,
  output rrr_pkg::sq_t  sq_o
);

  localparam rrr_pkg::acc_t SqLimit = rrr_pkg::acc_t'(1) <<< (rrr_pkg::WordBits - 2);

  // Stage 5: scale by the index ratio, as two partial products.
  logic          v5_q;
  rrr_pkg::mix_t c5_q;
  logic signed [rrr_pkg::HiProdBits-1:0] ph5_d [3];
  logic signed [rrr_pkg::HiProdBits-1:0] ph5_q [3];
  logic signed [rrr_pkg::LoProdBits-1:0] pl5_d [3];
  logic signed [rrr_pkg::LoProdBits-1:0] pl5_q [3];

  always_comb begin
    logic signed [rrr_pkg::WordBits-1:0]  eta;
    logic signed [rrr_pkg::HiBits-1:0]    hi;
    logic signed [rrr_pkg::SplitBits:0]   lo;
    eta = $signed({1'b0, mix_i.eta});
    for (int i = 0; i < 3; i++) begin
      hi = $signed(mix_i.mix[i][rrr_pkg::AccBits-1:rrr_pkg::SplitBits]);
      lo = $signed({1'b0, mix_i.mix[i][rrr_pkg::SplitBits-1:0]});
      ph5_d[i] = hi * eta;
      pl5_d[i] = lo * eta;
    end
  end

  // Stage 6: rescale to the perpendicular part and flag oversize components.
  logic                       v6_q;
  rrr_pkg::op_e               op6_q;
  rrr_pkg::word_t [2:0]       n6_q;
  rrr_pkg::acc_t  [2:0]       val6_d, val6_q;
  logic                       big6_d, big6_q;

  always_comb begin
    rrr_pkg::acc_t p;
    big6_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      p = rrr_pkg::fx_shift(rrr_pkg::pp_join(ph5_q[i], pl5_q[i]));
      if (p >= SqLimit || p < -SqLimit) begin
        big6_d = 1'b1;
      end
      val6_d[i] = (c5_q.op == rrr_pkg::OpRefract) ? p : c5_q.mix[i];
    end
  end

  // Stage 7: squares of the perpendicular components.
  logic                  v7_q;
  rrr_pkg::op_e          op7_q;
  rrr_pkg::word_t [2:0]  n7_q;
  rrr_pkg::acc_t  [2:0]  val7_q;
  rrr_pkg::acc_t  [2:0]  sq7_d, sq7_q;
  logic                  big7_q;

  always_comb begin
    logic signed [rrr_pkg::WordBits-2:0]     ps;
    logic signed [2*rrr_pkg::WordBits-3:0]   prod;
    for (int i = 0; i < 3; i++) begin
      ps       = $signed(val6_q[i][rrr_pkg::WordBits-2:0]);
      prod     = ps * ps;
      sq7_d[i] = rrr_pkg::fx_shift(prod);
    end
  end

  // Stage 8: k = 1 - |p|^2, the total internal reflection test and the root setup.
  logic         v8_q;
  rrr_pkg::sq_t sq8_d, sq8_q;

  always_comb begin
    rrr_pkg::acc_t k;
    k = rrr_pkg::One - (sq7_q[0] + sq7_q[1] + sq7_q[2]);
    sq8_d.op   = op7_q;
    sq8_d.norm = n7_q;
    sq8_d.val  = val7_q;
    sq8_d.root = '0;
    sq8_d.tir  = (op7_q == rrr_pkg::OpRefract) && (big7_q || k < 0);
    if (op7_q == rrr_pkg::OpRefract && !sq8_d.tir) begin
      sq8_d.rem = {k[rrr_pkg::FracBits+1:0], {rrr_pkg::FracBits{1'b0}}};
    end else begin
      sq8_d.rem = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else if (en_i) begin
      v5_q <= valid_i;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c5_q   <= mix_i;
      ph5_q  <= ph5_d;
      pl5_q  <= pl5_d;
      op6_q  <= c5_q.op;
      n6_q   <= c5_q.norm;
      val6_q <= val6_d;
      big6_q <= big6_d;
      op7_q  <= op6_q;
      n7_q   <= n6_q;
      val7_q <= val6_q;
      sq7_q  <= sq7_d;
      big7_q <= big6_q;
      sq8_q  <= sq8_d;
    end
  end

  assign valid_o = v8_q;
  assign sq_o    = sq8_q;

endmodule

>>> hw/rtl/rrr_sqrt.sv
module rrr_sqrt (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  rrr_pkg::sq_t sq_i,
  output logic         valid_o,
  output rrr_pkg::sq_t sq_o
);

  localparam int Stages = rrr_pkg::SqrtStages;
  localparam int Steps  = rrr_pkg::SqrtStepsPerStage;

  logic         v_q  [Stages];
  rrr_pkg::sq_t st_d [Stages];
  rrr_pkg::sq_t st_q [Stages];
  rrr_pkg::sq_t src  [Stages];
  logic         vsrc [Stages];

  // Each stage settles up to four root bits, most significant first, by the
  // restoring remainder method.
  for (genvar s = 0; s < Stages; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign src[s]  = sq_i;
      assign vsrc[s] = valid_i;
    end else begin : g_next
      assign src[s]  = st_q[s-1];
      assign vsrc[s] = v_q[s-1];
    end

    always_comb begin
      rrr_pkg::sq_t            w;
      logic [rrr_pkg::RemBits:0] trial;
      int                      b;
      w = src[s];
      for (int j = 0; j < Steps; j++) begin
        b = rrr_pkg::RootBits - 1 - (s * Steps + j);
        if (b >= 0) begin
          trial = ((rrr_pkg::RemBits + 1)'(w.root) << (b + 1))
                + ((rrr_pkg::RemBits + 1)'(1) << (2 * b));
          if (trial <= {1'b0, w.rem}) begin
            w.rem  = w.rem - trial[rrr_pkg::RemBits-1:0];
            w.root = w.root | (rrr_pkg::RootBits'(1) << b);
          end
        end
      end
      st_d[s] = w;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= vsrc[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  assign valid_o = v_q[Stages-1];
  assign sq_o    = st_q[Stages-1];

endmodule

>>> hw/rtl/rrr_back.sv
module rrr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  rrr_pkg::sq_t  sq_i,
  output logic          valid_o,
  output rrr_pkg::out_t out_o
);

  localparam rrr_pkg::acc_t WordMax = (rrr_pkg::acc_t'(1) <<< (rrr_pkg::WordBits - 1)) - 1;
  localparam rrr_pkg::acc_t WordMin = -(rrr_pkg::acc_t'(1) <<< (rrr_pkg::WordBits - 1));

  // Stage A: normal times minus the root.
  logic                 va_q;
  rrr_pkg::op_e         opa_q;
  logic                 tira_q;
  rrr_pkg::acc_t [2:0]  vala_q;
  rrr_pkg::acc_t [2:0]  qa_d, qa_q;

  always_comb begin
    logic signed [rrr_pkg::RootBits:0]                     root;
    logic signed [rrr_pkg::WordBits+rrr_pkg::RootBits:0]   prod;
    root = $signed({1'b0, sq_i.root});
    for (int i = 0; i < 3; i++) begin
      prod    = $signed(sq_i.norm[i]) * root;
      qa_d[i] = rrr_pkg::fx_shift(-prod);
    end
  end

  // Stage B: final sum, selection and saturation into the output register.
  logic          vb_q;
  rrr_pkg::out_t out_d, out_q;

  always_comb begin
    rrr_pkg::acc_t              res [3];
    logic [rrr_pkg::WordBits-1:0] sat [3];
    for (int i = 0; i < 3; i++) begin
      if (opa_q == rrr_pkg::OpRefract) begin
        res[i] = tira_q ? '0 : vala_q[i] + qa_q[i];
      end else begin
        res[i] = vala_q[i];
      end
      if (res[i] > WordMax) begin
        sat[i] = WordMax[rrr_pkg::WordBits-1:0];
      end else if (res[i] < WordMin) begin
        sat[i] = WordMin[rrr_pkg::WordBits-1:0];
      end else begin
        sat[i] = res[i][rrr_pkg::WordBits-1:0];
      end
    end
    out_d.out_x          = sat[0];
    out_d.out_y          = sat[1];
    out_d.out_z          = sat[2];
    out_d.total_internal = tira_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      opa_q  <= sq_i.op;
      tira_q <= sq_i.tir;
      vala_q <= sq_i.val;
      qa_q   <= qa_d;
      out_q  <= out_d;
    end
  end

  assign valid_o = vb_q;
  assign out_o   = out_q;

endmodule

>>> sim/ray_reflect_refract_checker.sv
`timescale 1ns / 1ps

module ray_reflect_refract_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  rrr_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  rrr_pkg::out_t out_data_i,
  output int            fail_count_o,
  output int            pending_o,
  output int            refract_count_o,
  output int            tir_count_o
);

  localparam longint ScaleOne = 64'sd1 << rrr_pkg::FracBits;
  localparam longint WordMax  = (64'sd1 <<< (rrr_pkg::WordBits - 1)) - 1;
  localparam longint WordMin  = -WordMax - 1;
  localparam longint I64Max   = 64'h7fff_ffff_ffff_ffff;
  localparam longint I64Min   = 64'h8000_0000_0000_0000;

  rrr_pkg::out_t expected_q[$];
  int            fails;

  // Saturating 64-bit add and negate.
  function automatic longint add_sat(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(I64Max)) return I64Max;
    if (s < 65'(I64Min)) return I64Min;
    return s[63:0];
  endfunction

  function automatic longint neg_sat(longint a);
    return (a == I64Min) ? I64Max : -a;
  endfunction

  // Exact product, floor-shifted by the fraction width, saturated to 64 bits.
  function automatic longint mul_fx(longint a, longint b);
    logic signed [127:0] p;
    p = (128'(a) * 128'(b)) >>> rrr_pkg::FracBits;
    if (p > 128'(I64Max)) return I64Max;
    if (p < 128'(I64Min)) return I64Min;
    return p[63:0];
  endfunction

  function automatic longint dot_fx(longint a[3], longint b[3]);
    return add_sat(add_sat(mul_fx(a[0], b[0]), mul_fx(a[1], b[1])), mul_fx(a[2], b[2]));
  endfunction

  // Floor of the square root of a fixed point value in [0, 1.0].
  function automatic longint root_fx(longint k);
    logic [127:0] goal, cand;
    logic [63:0]  r;
    goal = 128'(k) << rrr_pkg::FracBits;
    r = 0;
    for (int b = rrr_pkg::FracBits; b >= 0; b--) begin
      cand = 128'(r | (64'd1 << b));
      if (cand * cand <= goal) r = cand[63:0];
    end
    return r;
  endfunction

  function automatic rrr_pkg::word_t clamp_word(longint v);
    if (v > WordMax) return rrr_pkg::word_t'(WordMax);
    if (v < WordMin) return rrr_pkg::word_t'(WordMin);
    return rrr_pkg::word_t'(v);
  endfunction

  // Reflected or refracted direction for one input transaction.
  function automatic rrr_pkg::out_t bend_ray(rrr_pkg::in_t it);
    longint        d[3], n[3], nd[3], p[3], r[3];
    longint        dd, c, k, s, eta;
    rrr_pkg::out_t o;
    d = '{longint'(it.dir_x), longint'(it.dir_y), longint'(it.dir_z)};
    n = '{longint'(it.norm_x), longint'(it.norm_y), longint'(it.norm_z)};
    o.total_internal = 1'b0;
    if (it.opcode == rrr_pkg::OpReflect) begin
      dd = dot_fx(d, n);
      dd = add_sat(dd, dd);
      for (int i = 0; i < 3; i++) r[i] = add_sat(d[i], neg_sat(mul_fx(n[i], dd)));
    end else begin
      eta = longint'({1'b0, it.index_ratio});
      for (int i = 0; i < 3; i++) nd[i] = neg_sat(d[i]);
      c = dot_fx(nd, n);
      if (c > ScaleOne) c = ScaleOne;
      for (int i = 0; i < 3; i++) p[i] = mul_fx(add_sat(d[i], mul_fx(n[i], c)), eta);
      k = add_sat(ScaleOne, neg_sat(dot_fx(p, p)));
      if (k < 0) begin
        r = '{0, 0, 0};
        o.total_internal = 1'b1;
      end else begin
        s = root_fx(k);
        for (int i = 0; i < 3; i++) r[i] = add_sat(p[i], mul_fx(n[i], -s));
      end
    end
    o.out_x = clamp_word(r[0]);
    o.out_y = clamp_word(r[1]);
    o.out_z = clamp_word(r[2]);
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  // Predict on each accepted input, compare on each accepted output.
  always @(posedge clk_i) begin
    rrr_pkg::out_t want;
    if (!rst_ni) begin
      fails = 0;
      refract_count_o <= 0;
      tir_count_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        expected_q.push_back(bend_ray(in_data_i));
        if (in_data_i.opcode == rrr_pkg::OpRefract) refract_count_o <= refract_count_o + 1;
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", out_data_i.out_x, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_data_i.out_x !== want.out_x)
            report_mismatch("out_x", out_data_i.out_x, want.out_x);
          if (out_data_i.out_y !== want.out_y)
            report_mismatch("out_y", out_data_i.out_y, want.out_y);
          if (out_data_i.out_z !== want.out_z)
            report_mismatch("out_z", out_data_i.out_z, want.out_z);
          if (out_data_i.total_internal !== want.total_internal)
            report_mismatch("total_internal", out_data_i.total_internal, want.total_internal);
          if (want.total_internal) tir_count_o <= tir_count_o + 1;
        end
      end
    end
  end

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();
endmodule

>>> sim/ray_reflect_refract_top_test.sv
`timescale 1ns / 1ps

module ray_reflect_refract_top_test;

  localparam int RandomItems = 400;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 40;
  localparam rrr_pkg::word_t OneWord = rrr_pkg::word_t'(1) <<< rrr_pkg::FracBits;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  rrr_pkg::in_t  in_data_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  rrr_pkg::out_t out_data_o;
  int            fail_count, pending, refract_count, tir_count;
  int            cycle_count = 0;
  bit            calm = 1'b0;

  ray_reflect_refract_top dut (.*);

  ray_reflect_refract_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending),
    .refract_count_o(refract_count), .tir_count_o(tir_count)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Timeout watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver stalls in random bursts until the quiet tail of the run.
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 9);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  function automatic rrr_pkg::word_t pick_word();
    case ($urandom_range(0, 7))
      0: return rrr_pkg::word_t'(32'h7fff_ffff);
      1: return rrr_pkg::word_t'(32'h8000_0000);
      2: return rrr_pkg::word_t'($urandom);
      3: return rrr_pkg::word_t'(0);
      default: return rrr_pkg::word_t'($signed($urandom_range(0, 2 ** 29)) - (2 ** 28));
    endcase
  endfunction

  // Drive one transaction, with an optional sender gap first.
  task automatic send_ray(rrr_pkg::in_t it);
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 9);
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  initial begin
    rrr_pkg::in_t it;
    int           drain;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, both operations, grazing and total internal cases.
    it = '{rrr_pkg::OpReflect, 32'h7fff_ffff, 32'h8000_0000, 0, 32'h8000_0000,
           32'h7fff_ffff, 0, '1};
    send_ray(it);
    it.opcode = rrr_pkg::OpRefract; send_ray(it);
    it = '{rrr_pkg::OpReflect, 0, 0, -OneWord, 0, 0, OneWord, 0}; send_ray(it);
    it.opcode = rrr_pkg::OpRefract; send_ray(it);
    it.index_ratio = 31'(OneWord); send_ray(it);
    it.index_ratio = '1; send_ray(it);
    it = '{rrr_pkg::OpRefract, OneWord, 0, -(OneWord >>> 4), 0, 0, OneWord,
           31'(OneWord <<< 1)};
    send_ray(it);
    it.index_ratio = 31'(OneWord >>> 1); send_ray(it);
    it = '{rrr_pkg::OpRefract, 0, 0, OneWord, 0, 0, OneWord, 31'(OneWord)}; send_ray(it);
    it = '{rrr_pkg::OpRefract, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
           32'h8000_0000, 32'h8000_0000, '1};
    send_ray(it);
    it.opcode = rrr_pkg::OpReflect; send_ray(it);
    it = '{rrr_pkg::OpReflect, '1, '1, '1, '1, '1, '1, 0}; send_ray(it);

    // Random items, ending in a stretch with no idling.
    for (int i = 0; i < RandomItems; i++) begin
      if (i == RandomItems - 60) calm = 1'b1;
      it.opcode = rrr_pkg::op_e'($urandom_range(0, 1));
      it.dir_x  = pick_word();
      it.dir_y  = pick_word();
      it.dir_z  = pick_word();
      it.norm_x = pick_word();
      it.norm_y = pick_word();
      it.norm_z = pick_word();
      it.index_ratio = ($urandom_range(0, 3) == 0) ? 31'($urandom)
                       : 31'($urandom_range(0, 2 ** 29));
      send_ray(it);
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    for (drain = 0; drain < DrainCycles; drain++) @(posedge clk_i);

    $display("ran %0d directed and %0d random rays, %0d refractions, %0d total internal",
             12, RandomItems, refract_count, tir_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
